[sv/space_vector_pwm_duty_calc_assert.svh]
// ----------------------------------------------------------------------------
// Space vector PWM duty calculator assertion macros
// Shared assertion forms for the duty calculator pipeline checks.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_DUTY_CALC_ASSERT_SVH
`define SPACE_VECTOR_PWM_DUTY_CALC_ASSERT_SVH

// Implication checked in the same cycle.
`define SVPWM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked a fixed number of cycles later.
`define SVPWM_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

[sv/svpwm_pkg.sv]
// ----------------------------------------------------------------------------
// Space vector PWM duty calculator package
// Transaction types and sector codes shared by the duty calculator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int DATA_W = 32;

    // Sector codes: bit0 Va > 0, bit1 Vb > 0, bit2 Vc > 0.
    localparam logic [2:0] SEC_ZERO = 3'd0;
    localparam logic [2:0] SEC_A    = 3'd1;
    localparam logic [2:0] SEC_B    = 3'd2;
    localparam logic [2:0] SEC_AB   = 3'd3;
    localparam logic [2:0] SEC_C    = 3'd4;
    localparam logic [2:0] SEC_AC   = 3'd5;
    localparam logic [2:0] SEC_BC   = 3'd6;
    localparam logic [2:0] SEC_ALL  = 3'd7;

    // Input transaction: one stator voltage vector.
    typedef struct packed {
        logic signed [DATA_W-1:0] v_alpha;
        logic signed [DATA_W-1:0] v_beta;
    } vec_t;

    // Result transaction: three phase duties and the sector.
    typedef struct packed {
        logic signed [DATA_W-1:0] duty_a;
        logic signed [DATA_W-1:0] duty_b;
        logic signed [DATA_W-1:0] duty_c;
        logic [2:0]               sector_code;
    } result_t;

endpackage

[sv/space_vector_pwm_duty_calc.sv]
// A transaction accepted with start passes stages 1 to 4 and the output register before done rises.
// Throughput: one transaction per cycle; busy is always low.
// Depth is set by the five register stages around the single 32x32 multiplier.
// Results are shown for one cycle with done; the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) clears the valid bits only.
// ----------------------------------------------------------------------------
// Space vector PWM duty calculator
// Pipelined sector search and phase duty computation from an alpha/beta
// voltage vector in signed fixed point.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_calc #(
    parameter int FRAC_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  svpwm_pkg::vec_t   vec,
    output logic              done,
    output svpwm_pkg::result_t result
);

    localparam int W = svpwm_pkg::DATA_W;
    localparam int LATENCY = 5;
    localparam logic [63:0] K_WIDE = (64'd8660254 << FRAC_BITS) / 64'd10000000;
    localparam logic signed [W-1:0] K_SQRT3_2 = K_WIDE[W-1:0];
    localparam logic [63:0] ONE_WIDE = 64'd1 << FRAC_BITS;
    localparam logic [W-1:0] FX_ONE = ONE_WIDE[W-1:0];
    localparam logic [W-1:0] FX_HALF = ONE_WIDE[W:1];

    // Arithmetic halving with floor.
    function automatic logic [W-1:0] half_of(input logic [W-1:0] x);
        return {x[W-1], x[W-1:1]};
    endfunction

    // Strictly positive test on a two's complement word.
    function automatic logic is_pos(input logic [W-1:0] x);
        return (x != '0) && !x[W-1];
    endfunction

    // Map an on-time to a signed duty: 2*(t - 0.5).
    function automatic logic [W-1:0] to_duty(input logic [W-1:0] t);
        logic [W-1:0] d;
        d = t - FX_HALF;
        return {d[W-2:0], 1'b0};
    endfunction

    logic accept;

    // Every cycle can take a new transaction.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage 1: capture the input vector.
    logic                 s1_valid_reg;
    logic signed [W-1:0]  s1_alpha_reg;
    logic [W-1:0]         s1_beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_alpha_reg <= vec.v_alpha;
            s1_beta_reg  <= vec.v_beta;
        end
    end

    // Stage 2: full product k * alpha.
    logic                   s2_valid_reg;
    logic signed [2*W-1:0]  s2_prod_reg;
    logic [W-1:0]           s2_beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_prod_reg <= K_SQRT3_2 * s1_alpha_reg;
        s2_beta_reg <= s1_beta_reg;
    end

    // Stage 3: X/Y/Z times and the sector code from the phase voltage signs.
    logic           s3_valid_reg;
    logic [W-1:0]   s3_x_reg;
    logic [W-1:0]   s3_y_reg;
    logic [W-1:0]   s3_z_reg;
    logic [2:0]     s3_sec_reg;
    logic [W-1:0]   ka;
    logic [W-1:0]   hb;
    logic [W-1:0]   y_next;
    logic [W-1:0]   z_next;
    logic [2:0]     sec_next;

    always_comb
    begin
        // The floor shift keeps product bits above the fraction.
        ka       = s2_prod_reg[FRAC_BITS+W-1:FRAC_BITS];
        hb       = half_of(s2_beta_reg);
        y_next   = hb + ka;
        z_next   = hb - ka;
        sec_next = {is_pos(W'(0) - hb - ka), is_pos(ka - hb), is_pos(s2_beta_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_x_reg   <= s2_beta_reg;
        s3_y_reg   <= y_next;
        s3_z_reg   <= z_next;
        s3_sec_reg <= sec_next;
    end

    // Stage 4: pick the two active vector times and form the base on-time.
    logic           s4_valid_reg;
    logic [W-1:0]   s4_t1_reg;
    logic [W-1:0]   s4_t2_reg;
    logic [W-1:0]   s4_base_reg;
    logic [2:0]     s4_sec_reg;
    logic [W-1:0]   t1_next;
    logic [W-1:0]   t2_next;

    always_comb
    begin
        case (s3_sec_reg)
            svpwm_pkg::SEC_A:
            begin
                t1_next = s3_z_reg;
                t2_next = s3_y_reg;
            end
            svpwm_pkg::SEC_B:
            begin
                t1_next = s3_y_reg;
                t2_next = W'(0) - s3_x_reg;
            end
            svpwm_pkg::SEC_AB:
            begin
                t1_next = W'(0) - s3_z_reg;
                t2_next = s3_x_reg;
            end
            svpwm_pkg::SEC_C:
            begin
                t1_next = W'(0) - s3_x_reg;
                t2_next = s3_z_reg;
            end
            svpwm_pkg::SEC_AC:
            begin
                t1_next = s3_x_reg;
                t2_next = W'(0) - s3_y_reg;
            end
            svpwm_pkg::SEC_BC:
            begin
                t1_next = W'(0) - s3_y_reg;
                t2_next = W'(0) - s3_z_reg;
            end
            default:
            begin
                t1_next = '0;
                t2_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_t1_reg   <= t1_next;
        s4_t2_reg   <= t2_next;
        s4_base_reg <= half_of(FX_ONE - t1_next - t2_next);
        s4_sec_reg  <= s3_sec_reg;
    end

    // Stage 5: cumulative on-times, phase assignment and duty mapping.
    logic           done_reg;
    svpwm_pkg::result_t result_reg;
    logic [W-1:0]   sum1;
    logic [W-1:0]   sum2;
    logic [W-1:0]   ta;
    logic [W-1:0]   tb;
    logic [W-1:0]   tc;

    always_comb
    begin
        sum1 = s4_base_reg + s4_t1_reg;
        sum2 = sum1 + s4_t2_reg;
        case (s4_sec_reg)
            svpwm_pkg::SEC_A:
            begin
                tb = s4_base_reg; ta = sum1; tc = sum2;
            end
            svpwm_pkg::SEC_B:
            begin
                ta = s4_base_reg; tc = sum1; tb = sum2;
            end
            svpwm_pkg::SEC_AB:
            begin
                ta = s4_base_reg; tb = sum1; tc = sum2;
            end
            svpwm_pkg::SEC_C:
            begin
                tc = s4_base_reg; tb = sum1; ta = sum2;
            end
            svpwm_pkg::SEC_AC:
            begin
                tb = s4_base_reg; tc = sum1; ta = sum2;
            end
            svpwm_pkg::SEC_BC:
            begin
                tc = s4_base_reg; ta = sum1; tb = sum2;
            end
            default:
            begin
                // Zero vector, or all signs positive after wrap-around.
                ta = FX_HALF; tb = FX_HALF; tc = FX_HALF;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.duty_a      <= to_duty(ta);
        result_reg.duty_b      <= to_duty(tb);
        result_reg.duty_c      <= to_duty(tc);
        result_reg.sector_code <= s4_sec_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks on the pipeline timing and the zero-vector case.
    `include "space_vector_pwm_duty_calc_assert.svh"

    `SVPWM_ASSERT_DELAY(a_latency, accept, LATENCY, done,
        "accepted transaction gave no result on time")
    `SVPWM_ASSERT_SAME(a_no_invented, done, $past(accept, LATENCY),
        "result without a matching transaction")
    `SVPWM_ASSERT_SAME(a_zero_vector,
        done && (result.sector_code == svpwm_pkg::SEC_ZERO ||
                 result.sector_code == svpwm_pkg::SEC_ALL),
        result.duty_a == '0 && result.duty_b == '0 && result.duty_c == '0,
        "zero vector gave nonzero duty")

endmodule

[tb/space_vector_pwm_duty_calc_test.sv]
// ----------------------------------------------------------------------------
// Space vector PWM duty calculator testbench
// Sends alpha/beta voltage vectors through the start/busy command port with
// random idle gaps. It predicts the sector and the three phase duties of each
// accepted vector in a scoreboard, and checks every done strobe against the
// oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module space_vector_pwm_duty_calc_test;

    localparam int FRAC_BITS = 24;
    localparam int CLK_HALF  = 4;
    localparam int NUM_RAND  = 600;

    // Scoreboard: predicts duties for accepted vectors and checks results.
    class duty_scoreboard;

        localparam logic [31:0] K_COEF  =
            32'((64'd8660254 << FRAC_BITS) / 64'd10000000);
        localparam logic [31:0] FX_ONE  = 32'd1 << FRAC_BITS;
        localparam logic [31:0] FX_HALF = 32'd1 << (FRAC_BITS - 1);

        svpwm_pkg::result_t duty_q[$];
        int                 errors;

        function new();
            errors = 0;
        endfunction

        static function logic [31:0] halve(logic [31:0] x);
            return {x[31], x[31:1]};
        endfunction

        static function bit is_pos(logic [31:0] x);
            return (x != 32'd0) && !x[31];
        endfunction

        static function logic [31:0] to_duty(logic [31:0] t);
            return (t - FX_HALF) << 1;
        endfunction

        // Sector search from the inverse-Clarke signs, then per-sector on-times.
        static function svpwm_pkg::result_t predict_duties(svpwm_pkg::vec_t v);
            logic [31:0]        beta, hb, ka, x, y, z, t1, t2, ta, tb, tc;
            logic [2:0]         sec;
            longint             prod;
            svpwm_pkg::result_t r;
            beta = v.v_beta;
            hb   = halve(beta);
            prod = longint'(K_COEF) * longint'(v.v_alpha);
            ka   = 32'(prod >>> FRAC_BITS);
            sec  = svpwm_pkg::SEC_ZERO;
            if (is_pos(beta))
                sec[0] = 1'b1;
            if (is_pos(ka - hb))
                sec[1] = 1'b1;
            if (is_pos(32'd0 - hb - ka))
                sec[2] = 1'b1;
            x = beta;
            y = hb + ka;
            z = hb - ka;
            case (sec)
                svpwm_pkg::SEC_A:
                begin
                    t1 = z; t2 = y;
                    tb = halve(FX_ONE - t1 - t2);
                    ta = tb + t1;
                    tc = ta + t2;
                end
                svpwm_pkg::SEC_B:
                begin
                    t1 = y; t2 = 32'd0 - x;
                    ta = halve(FX_ONE - t1 - t2);
                    tc = ta + t1;
                    tb = tc + t2;
                end
                svpwm_pkg::SEC_AB:
                begin
                    t1 = 32'd0 - z; t2 = x;
                    ta = halve(FX_ONE - t1 - t2);
                    tb = ta + t1;
                    tc = tb + t2;
                end
                svpwm_pkg::SEC_C:
                begin
                    t1 = 32'd0 - x; t2 = z;
                    tc = halve(FX_ONE - t1 - t2);
                    tb = tc + t1;
                    ta = tb + t2;
                end
                svpwm_pkg::SEC_AC:
                begin
                    t1 = x; t2 = 32'd0 - y;
                    tb = halve(FX_ONE - t1 - t2);
                    tc = tb + t1;
                    ta = tc + t2;
                end
                svpwm_pkg::SEC_BC:
                begin
                    t1 = 32'd0 - y; t2 = 32'd0 - z;
                    tc = halve(FX_ONE - t1 - t2);
                    ta = tc + t1;
                    tb = ta + t2;
                end
                // The zero vector and the all-positive wrap case both center.
                default:
                begin
                    ta = FX_HALF; tb = FX_HALF; tc = FX_HALF;
                end
            endcase
            r.duty_a      = to_duty(ta);
            r.duty_b      = to_duty(tb);
            r.duty_c      = to_duty(tc);
            r.sector_code = sec;
            return r;
        endfunction

        // One line per mismatch, and the count goes up.
        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function void note_vector(svpwm_pkg::vec_t v);
            duty_q.push_back(predict_duties(v));
        endfunction

        task check_result(svpwm_pkg::result_t got);
            svpwm_pkg::result_t want;
            if (duty_q.size() == 0)
            begin
                report("result strobe with no transaction outstanding");
                return;
            end
            want = duty_q.pop_front();
            if (got.duty_a !== want.duty_a)
                report($sformatf("duty_a got %h want %h", got.duty_a, want.duty_a));
            if (got.duty_b !== want.duty_b)
                report($sformatf("duty_b got %h want %h", got.duty_b, want.duty_b));
            if (got.duty_c !== want.duty_c)
                report($sformatf("duty_c got %h want %h", got.duty_c, want.duty_c));
            if (got.sector_code !== want.sector_code)
                report($sformatf("sector_code got %0d want %0d",
                                 got.sector_code, want.sector_code));
        endtask

        task finish_check();
            if (duty_q.size() != 0)
                report($sformatf("%0d results never arrived", duty_q.size()));
        endtask

    endclass

    logic               clk    = 1'b0;
    logic               rst_n  = 1'b0;
    logic               start  = 1'b0;
    svpwm_pkg::vec_t    vec    = '0;
    logic               busy;
    logic               done;
    svpwm_pkg::result_t result;

    int burst_left = 0;

    duty_scoreboard sb;

    space_vector_pwm_duty_calc #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .vec   (vec),
        .done  (done),
        .result(result)
    );

    // Clock generation.
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Input side: a transaction is taken when start is high and busy is low.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_vector(vec);
    end

    // Output side: every done strobe is a result that must be checked.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // Mostly back-to-back or short gaps, a few long ones, and bursts with none.
    function int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Operand mix: nominal range, full range, near the extremes, tiny values.
    function logic [31:0] random_field();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return int'($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS);
        if (r < 70)
            return $urandom;
        if (r < 85)
        begin
            if ($urandom_range(0, 1))
                return 32'h7fffffff - $urandom_range(0, 255);
            return 32'h80000000 + $urandom_range(0, 255);
        end
        return int'($urandom_range(0, 32)) - 16;
    endfunction

    // Idle for the gap with junk on the bus, then hold start until accepted.
    task drive_vector(logic [31:0] alpha, logic [31:0] beta, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            vec   <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        vec   <= {alpha, beta};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stimulus, drain and verdict.
    initial
    begin
        int wait_cycles;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero vector, smallest steps and the field extremes.
        drive_vector(32'd0, 32'd0, next_gap());
        drive_vector(32'd1, 32'd0, next_gap());
        drive_vector(-32'sd1, 32'd0, next_gap());
        drive_vector(32'd0, 32'd1, next_gap());
        drive_vector(32'd0, -32'sd1, next_gap());
        drive_vector(32'h7fffffff, 32'd0, next_gap());
        drive_vector(32'h80000000, 32'd0, next_gap());
        drive_vector(32'd0, 32'h7fffffff, next_gap());
        drive_vector(32'd0, 32'h80000000, next_gap());
        // Both at maximum wraps into the all-positive sector code.
        drive_vector(32'h7fffffff, 32'h7fffffff, next_gap());
        drive_vector(32'h80000000, 32'h80000000, next_gap());
        drive_vector(32'h7fffffff, 32'h80000000, next_gap());
        drive_vector(32'h80000000, 32'h7fffffff, next_gap());
        drive_vector(32'hffffffff, 32'hffffffff, next_gap());
        // Half-amplitude vectors at 90, 30, 330, 150, 210 and 270 degrees.
        drive_vector(32'd0, 32'sd8388608, next_gap());
        drive_vector(32'sd7264748, 32'sd4194304, next_gap());
        drive_vector(32'sd7264748, -32'sd4194304, next_gap());
        drive_vector(-32'sd7264748, 32'sd4194304, next_gap());
        drive_vector(-32'sd7264748, -32'sd4194304, next_gap());
        drive_vector(32'd0, -32'sd8388608, next_gap());
        // Full-scale nominal vector and one beyond the linear range.
        drive_vector(32'sd16777216, 32'd0, next_gap());
        drive_vector(-32'sd16777216, 32'sd16777216, next_gap());

        // Random part.
        for (int i = 0; i < NUM_RAND; i++)
            drive_vector(random_field(), random_field(), next_gap());
        start <= 1'b0;

        // Drain the pipeline, then a few cycles to catch stray strobes.
        wait_cycles = 0;
        while (sb.duty_q.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        sb.finish_check();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("ERROR: simulation timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
